/* rtl/core/lzwc_pkg.sv */
// lzwc_pkg: shared types and constants for the lzw code decoder
// no dependencies
`timescale 1ns / 1ps

package lzwc_pkg;

    localparam int CODE_W         = 12;
    localparam int SYM_W          = 8;
    localparam int ALPHA_W        = 9;
    localparam int CNT_W          = 4;
    localparam int OUT_W          = 64;
    localparam int BYTES_PER_ITEM = 8;
    localparam int TABLE_SIZE_DEF = 4096;
    localparam int MAX_STRING_DEF = 512;
    localparam int ALPHA_RESET    = 256;
    localparam int ALPHA_MIN      = 2;
    localparam int ALPHA_MAX      = 256;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;

    typedef enum logic {
        K_DECODE  = 1'b0,
        K_RESTART = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [CODE_W-1:0]   code;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_WALK1,
        S_WALK2,
        S_GATHER,
        S_ERR
    } t_state;

endpackage

/* rtl/core/lzw_code_decoder.sv */
// lzw_code_decoder: lzw decoder top level, front register, queue and back part
// depends on lzwc_pkg, lzwc_front, lzwc_queue, lzwc_back
`timescale 1ns / 1ps
//
// usage: input items carry mode and a 12-bit code; mode 1 restarts the stream and
// yields nothing, mode 0 expands the code. each decoded string comes out as results
// of up to eight symbols (first symbol in the lowest byte) with last on the final one.
// bad codes give one result with status 1; strings over MAX_STRING are cut and carry
// status 2. a write on the config port sets the alphabet size and restarts the stream.
// the back part walks the prefix chain of a string twice at one dictionary read per
// cycle, then gathers each result of up to eight symbols from the string stack.
// items pass through the input register and the queue before they reach the back part.
// a two-entry queue plus the input register buffer items while the back part works.
// reset clears the stream (alphabet 256, empty dictionary) and empties the queue.
// if the receiver stalls, the result register holds and the back part waits; input
// items keep being taken until the queue fills, then the input stall rises.
//

module lzw_code_decoder #(
    parameter int TABLE_SIZE = lzwc_pkg::TABLE_SIZE_DEF,
    parameter int MAX_STRING = lzwc_pkg::MAX_STRING_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lzwc_pkg::ALPHA_W-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_mode,
    input  logic [lzwc_pkg::CODE_W-1:0]  i_code,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [lzwc_pkg::OUT_W-1:0]   o_symbols,
    output logic [lzwc_pkg::CNT_W-1:0]   o_symbol_count,
    output logic                         o_last,
    output logic [1:0]                   o_status
);

    logic            q_full;
    logic            push;
    lzwc_pkg::t_item f_item;
    logic            q_valid;
    lzwc_pkg::t_item q_item;
    logic            pop;

    lzwc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_mode     (i_mode),
        .i_code     (i_code),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_item     (f_item)
    );

    lzwc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    lzwc_back #(
        .TABLE_SIZE (TABLE_SIZE),
        .MAX_STRING (MAX_STRING)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_symbols      (o_symbols),
        .o_symbol_count (o_symbol_count),
        .o_last         (o_last),
        .o_status       (o_status)
    );

endmodule

/* rtl/core/lzwc_front.sv */
// lzwc_front: input register that accepts items and classifies them
// depends on lzwc_pkg
`timescale 1ns / 1ps

module lzwc_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_mode,
    input  logic [lzwc_pkg::CODE_W-1:0] i_code,
    input  logic                        i_q_full,
    output logic                        o_push,
    output lzwc_pkg::t_item             o_item
);

    logic            r_valid;
    logic            n_valid;
    lzwc_pkg::t_item r_item;
    logic            accept;

    assign o_in_stall = r_valid & i_q_full;
    assign accept     = i_in_valid & ~o_in_stall;
    assign o_push     = r_valid & ~i_q_full;
    assign o_item     = r_item;
    assign n_valid    = accept | (r_valid & i_q_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.kind <= i_mode ? lzwc_pkg::K_RESTART : lzwc_pkg::K_DECODE;
            r_item.code <= i_code;
        end
    end

endmodule

/* rtl/core/lzwc_queue.sv */
// lzwc_queue: two-entry queue between the front and back parts
// depends on lzwc_pkg
`timescale 1ns / 1ps

module lzwc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lzwc_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output lzwc_pkg::t_item o_item
);

    lzwc_pkg::t_item r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic [1:0]      n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !(i_pop && o_valid)) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop && o_valid) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop && o_valid) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

/* rtl/core/lzwc_back.sv */
// lzwc_back: dictionary, prefix chain walk, string stack and result register
// depends on lzwc_pkg
`timescale 1ns / 1ps

module lzwc_back #(
    parameter int TABLE_SIZE = lzwc_pkg::TABLE_SIZE_DEF,
    parameter int MAX_STRING = lzwc_pkg::MAX_STRING_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lzwc_pkg::ALPHA_W-1:0]   i_cfg_data,
    input  logic                           i_q_valid,
    input  lzwc_pkg::t_item                i_q_item,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [lzwc_pkg::OUT_W-1:0]     o_symbols,
    output logic [lzwc_pkg::CNT_W-1:0]     o_symbol_count,
    output logic                           o_last,
    output logic [1:0]                     o_status
);

    localparam int AW  = $clog2(TABLE_SIZE);
    localparam int NW  = $clog2(TABLE_SIZE + 1);
    localparam int WW  = (NW > lzwc_pkg::CODE_W) ? NW : lzwc_pkg::CODE_W;
    localparam int LW  = NW + 1;
    localparam int SW  = $clog2(MAX_STRING + 1);
    localparam int SAW = $clog2(MAX_STRING);
    localparam int CW  = lzwc_pkg::CODE_W;
    localparam int YW  = lzwc_pkg::SYM_W;
    localparam int AL  = lzwc_pkg::ALPHA_W;

    function automatic logic [AL-1:0] eff_alpha(input logic [AL-1:0] a);
        logic [AL-1:0] r;
        r = a;
        if (r < AL'(lzwc_pkg::ALPHA_MIN)) r = AL'(lzwc_pkg::ALPHA_MIN);
        if (r > AL'(lzwc_pkg::ALPHA_MAX)) r = AL'(lzwc_pkg::ALPHA_MAX);
        if (int'(r) > TABLE_SIZE) r = AL'(TABLE_SIZE);
        return r;
    endfunction

    logic [CW-1:0] r_prefix [TABLE_SIZE];
    logic [YW-1:0] r_suffix [TABLE_SIZE];
    logic [YW-1:0] r_stack  [MAX_STRING];
    logic [CW-1:0] r_prefix_rd;
    logic [YW-1:0] r_suffix_rd;
    logic [YW-1:0] r_stack_rd;

    lzwc_pkg::t_state r_state, n_state;

    logic [AL-1:0]  r_alpha, n_alpha;
    logic [NW-1:0]  r_nf, n_nf;
    logic [CW-1:0]  r_prior, n_prior;
    logic           r_have, n_have;
    logic [YW-1:0]  r_prior_first, n_prior_first;
    logic [CW-1:0]  r_c, n_c;
    logic           r_wr_en, n_wr_en;
    logic [CW-1:0]  r_wprior, n_wprior;
    logic [CW-1:0]  r_e, n_e;
    logic           r_pend, n_pend;
    logic [LW-1:0]  r_len, n_len;
    logic [YW-1:0]  r_e_end, n_e_end;
    logic [LW-1:0]  r_pos, n_pos;
    logic [LW-1:0]  r_wpos, n_wpos;
    logic [SW-1:0]  r_left, n_left;
    logic [SW-1:0]  r_base, n_base;
    logic [3:0]     r_iss, n_iss;
    logic [3:0]     r_got, n_got;
    logic [2:0]     r_pidx, n_pidx;
    logic           r_spend, n_spend;
    logic [lzwc_pkg::OUT_W-1:0] r_w, n_w;

    logic                       r_o_valid, n_o_valid;
    logic [lzwc_pkg::OUT_W-1:0] r_o_sym, n_o_sym;
    logic [lzwc_pkg::CNT_W-1:0] r_o_cnt, n_o_cnt;
    logic                       r_o_last, n_o_last;
    logic [1:0]                 r_o_status, n_o_status;

    logic            out_free;
    logic [CW-1:0]   cur_e;
    logic [WW-1:0]   cur_ext;
    logic [WW-1:0]   c_ext;
    logic [WW-1:0]   nf_ext;
    logic [WW-1:0]   alpha_ext;
    logic            cur_big;
    logic            trunc;
    logic [SW-1:0]   n_sym;
    logic [3:0]      chunk;
    logic            dec_valid;
    logic            dec_kwk;
    logic            room;

    logic            p_re;
    logic [AW-1:0]   p_raddr;
    logic            p_we;
    logic [AW-1:0]   p_waddr;
    logic [CW-1:0]   p_wprefix;
    logic [YW-1:0]   p_wsuffix;
    logic            s_we;
    logic [SAW-1:0]  s_waddr;
    logic [YW-1:0]   s_wdata;
    logic            s_re;
    logic [SW-1:0]   s_raddr_full;

    assign out_free  = ~r_o_valid | ~i_out_stall;
    assign cur_e     = r_pend ? r_prefix_rd : r_e;
    assign cur_ext   = WW'(cur_e);
    assign c_ext     = WW'(r_c);
    assign nf_ext    = WW'(r_nf);
    assign alpha_ext = WW'(r_alpha);
    assign cur_big   = (cur_ext >= alpha_ext);
    assign room      = (r_nf < NW'(TABLE_SIZE));
    assign trunc     = (r_len > LW'(MAX_STRING));
    assign n_sym     = trunc ? SW'(MAX_STRING) : SW'(r_len);
    assign chunk     = (r_left > SW'(lzwc_pkg::BYTES_PER_ITEM))
                       ? 4'(lzwc_pkg::BYTES_PER_ITEM) : r_left[3:0];
    assign dec_kwk   = ~(c_ext < alpha_ext) & ~(c_ext < nf_ext) & r_have
                       & (c_ext == nf_ext) & room;
    assign dec_valid = (c_ext < alpha_ext) | (c_ext < nf_ext) | dec_kwk;
    assign o_pop     = (r_state == lzwc_pkg::S_IDLE) & i_q_valid;

    always_comb begin
        n_state       = r_state;
        n_alpha       = r_alpha;
        n_nf          = r_nf;
        n_prior       = r_prior;
        n_have        = r_have;
        n_prior_first = r_prior_first;
        n_c           = r_c;
        n_wr_en       = r_wr_en;
        n_wprior      = r_wprior;
        n_e           = r_e;
        n_pend        = r_pend;
        n_len         = r_len;
        n_e_end       = r_e_end;
        n_pos         = r_pos;
        n_wpos        = r_wpos;
        n_left        = r_left;
        n_base        = r_base;
        n_iss         = r_iss;
        n_got         = r_got;
        n_pidx        = r_pidx;
        n_spend       = 1'b0;
        n_w           = r_w;
        n_o_valid     = r_o_valid & i_out_stall;
        n_o_sym       = r_o_sym;
        n_o_cnt       = r_o_cnt;
        n_o_last      = r_o_last;
        n_o_status    = r_o_status;
        p_re          = 1'b0;
        p_raddr       = cur_ext[AW-1:0];
        p_we          = 1'b0;
        p_waddr       = r_nf[AW-1:0];
        p_wprefix     = r_prior;
        p_wsuffix     = r_prior_first;
        s_we          = 1'b0;
        s_waddr       = '0;
        s_wdata       = r_e_end;
        s_re          = 1'b0;
        s_raddr_full  = r_base + SW'(r_iss);

        unique case (r_state)
            lzwc_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_item.kind == lzwc_pkg::K_RESTART) begin
                        n_nf    = NW'(r_alpha);
                        n_prior = '0;
                        n_have  = 1'b0;
                    end else begin
                        n_c     = i_q_item.code;
                        n_state = lzwc_pkg::S_DECIDE;
                    end
                end
            end
            lzwc_pkg::S_DECIDE: begin
                if (!dec_valid) begin
                    n_state = lzwc_pkg::S_ERR;
                end else begin
                    if (dec_kwk) begin
                        p_we    = 1'b1;
                        n_nf    = r_nf + NW'(1);
                        n_wr_en = 1'b0;
                    end else begin
                        n_wr_en = r_have & room;
                    end
                    n_wprior = r_prior;
                    n_prior  = r_c;
                    n_have   = 1'b1;
                    n_e      = r_c;
                    n_pend   = 1'b0;
                    n_len    = LW'(1);
                    n_state  = lzwc_pkg::S_WALK1;
                end
            end
            lzwc_pkg::S_WALK1: begin
                if (cur_big) begin
                    p_re   = 1'b1;
                    n_len  = r_len + LW'(1);
                    n_pend = 1'b1;
                end else begin
                    n_e_end       = cur_e[YW-1:0];
                    n_prior_first = cur_e[YW-1:0];
                    if (r_wr_en) begin
                        p_we      = 1'b1;
                        p_wprefix = r_wprior;
                        p_wsuffix = cur_e[YW-1:0];
                        n_nf      = r_nf + NW'(1);
                    end
                    n_e     = r_c;
                    n_pend  = 1'b0;
                    n_pos   = r_len;
                    n_state = lzwc_pkg::S_WALK2;
                end
            end
            lzwc_pkg::S_WALK2: begin
                if (r_pend) begin
                    if (r_wpos < LW'(n_sym)) begin
                        s_we    = 1'b1;
                        s_waddr = r_wpos[SAW-1:0];
                        s_wdata = r_suffix_rd;
                    end
                end else begin
                    s_we    = 1'b1;
                    s_waddr = '0;
                    s_wdata = r_e_end;
                end
                if (cur_big) begin
                    p_re   = 1'b1;
                    n_pos  = r_pos - LW'(1);
                    n_wpos = r_pos - LW'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_left  = n_sym;
                    n_base  = '0;
                    n_iss   = '0;
                    n_got   = '0;
                    n_w     = '0;
                    n_state = lzwc_pkg::S_GATHER;
                end
            end
            lzwc_pkg::S_GATHER: begin
                if (r_spend) begin
                    n_w[r_pidx*8 +: 8] = r_stack_rd;
                    n_got              = r_got + 4'd1;
                end
                if (r_iss < chunk) begin
                    s_re    = 1'b1;
                    n_spend = 1'b1;
                    n_pidx  = r_iss[2:0];
                    n_iss   = r_iss + 4'd1;
                end
                if (!r_spend && r_got == chunk && out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_sym    = r_w;
                    n_o_cnt    = chunk;
                    n_o_last   = (r_left == SW'(chunk));
                    n_o_status = trunc ? lzwc_pkg::ST_TRUNC : lzwc_pkg::ST_OK;
                    n_left     = r_left - SW'(chunk);
                    n_base     = r_base + SW'(chunk);
                    n_iss      = '0;
                    n_got      = '0;
                    n_w        = '0;
                    n_spend    = 1'b0;
                    if (r_left == SW'(chunk)) begin
                        n_state = lzwc_pkg::S_IDLE;
                    end
                end
            end
            lzwc_pkg::S_ERR: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_sym    = '0;
                    n_o_cnt    = '0;
                    n_o_last   = 1'b1;
                    n_o_status = lzwc_pkg::ST_INVALID;
                    n_state    = lzwc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lzwc_pkg::S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_alpha = eff_alpha(i_cfg_data);
            n_nf    = NW'(eff_alpha(i_cfg_data));
            n_prior = '0;
            n_have  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lzwc_pkg::S_IDLE;
            r_alpha   <= eff_alpha(AL'(lzwc_pkg::ALPHA_RESET));
            r_nf      <= NW'(eff_alpha(AL'(lzwc_pkg::ALPHA_RESET)));
            r_prior   <= '0;
            r_have    <= 1'b0;
            r_pend    <= 1'b0;
            r_spend   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_alpha   <= n_alpha;
            r_nf      <= n_nf;
            r_prior   <= n_prior;
            r_have    <= n_have;
            r_pend    <= n_pend;
            r_spend   <= n_spend;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prior_first <= n_prior_first;
        r_c           <= n_c;
        r_wr_en       <= n_wr_en;
        r_wprior      <= n_wprior;
        r_e           <= n_e;
        r_len         <= n_len;
        r_e_end       <= n_e_end;
        r_pos         <= n_pos;
        r_wpos        <= n_wpos;
        r_left        <= n_left;
        r_base        <= n_base;
        r_iss         <= n_iss;
        r_got         <= n_got;
        r_pidx        <= n_pidx;
        r_w           <= n_w;
        r_o_sym       <= n_o_sym;
        r_o_cnt       <= n_o_cnt;
        r_o_last      <= n_o_last;
        r_o_status    <= n_o_status;
    end

    // dictionary
    always_ff @(posedge i_clk) begin
        if (p_we) begin
            r_prefix[p_waddr] <= p_wprefix;
            r_suffix[p_waddr] <= p_wsuffix;
        end
        if (p_re) begin
            r_prefix_rd <= r_prefix[p_raddr];
            r_suffix_rd <= r_suffix[p_raddr];
        end
    end

    // string stack
    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_stack[s_waddr] <= s_wdata;
        end
        if (s_re) begin
            r_stack_rd <= r_stack[s_raddr_full[SAW-1:0]];
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_symbols      = r_o_sym;
    assign o_symbol_count = r_o_cnt;
    assign o_last         = r_o_last;
    assign o_status       = r_o_status;

    a_nf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (NW'(r_alpha) <= r_nf) && (r_nf <= NW'(TABLE_SIZE)))
        else $error("next free entry out of range");

    a_gather_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lzwc_pkg::S_GATHER) |-> (r_left != '0))
        else $error("gather with nothing left");

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status == lzwc_pkg::ST_INVALID)
        |-> (r_o_last && r_o_cnt == '0))
        else $error("invalid result malformed");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status != lzwc_pkg::ST_INVALID)
        |-> (r_o_cnt != '0 && r_o_cnt <= 4'(lzwc_pkg::BYTES_PER_ITEM)))
        else $error("result count out of range");

endmodule
